[design/led_keyframe_fade_engine_top_defines.svh]
// Assertion macros shared by the fade engine RTL.
`ifndef LED_KEYFRAME_FADE_ENGINE_TOP_DEFINES_SVH
`define LED_KEYFRAME_FADE_ENGINE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define LKF_ASSERT_IMP(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
	else $error("%m: assertion failed");
`define LKF_ASSERT_NXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
	else $error("%m: assertion failed");
`else
`define LKF_ASSERT_IMP(label, clk, rst_n, a, b)
`define LKF_ASSERT_NXT(label, clk, rst_n, a, b)
`endif
`endif

[design/lkf_pkg.sv]
// Package: shared types, constants and helpers of the fade engine.
`default_nettype none
package lkf_pkg;
	localparam int NUM_FRAMES   = 64;
	localparam int NUM_CHANNELS = 4;
	localparam int FW = $clog2(NUM_FRAMES);
	localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int LAST_CH = NUM_CHANNELS - 1;

	localparam logic [1:0] MODE_TICK   = 2'd0;
	localparam logic [1:0] MODE_WRITE  = 2'd1;
	localparam logic [1:0] MODE_COMMIT = 2'd2;

	localparam logic [1:0] PH_STATIC = 2'd0;
	localparam logic [1:0] PH_HOLD   = 2'd1;
	localparam logic [1:0] PH_DECAY  = 2'd2;

	localparam logic [24:0] ONE_Q24 = 25'h1000000;

	typedef struct packed {
		logic [7:0]    r;
		logic [7:0]    g;
		logic [7:0]    b;
		logic [7:0]    decay;
		logic [7:0]    hold;
		logic [FW-1:0] link;
	} frame_t;

	// controller -> datapath commands
	typedef struct packed {
		logic           stage_wr;   // write staging entry
		logic           copy_go;    // copy one entry staging->active
		logic [FW-1:0]  copy_idx;
		logic           rd_cur;     // read current frame of channel
		logic           rd_nxt;     // read linked frame
		logic           rd_start;   // read commit start frame
		logic           adv;        // apply advance for channel
		logic           start;      // start channel at commit frame
		logic           emit;       // load output register
		logic [CW-1:0]  ch;
		logic           last;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
	} sts_t;
endpackage
`default_nettype wire

[design/lkf_datapath.sv]
// Datapath: frame tables, channel state, crossfade mix and output register.
`default_nettype none
module lkf_datapath (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire lkf_pkg::cmd_t      cmd,
	output lkf_pkg::sts_t           sts,
	input  wire lkf_pkg::frame_t    wr_frame,
	input  wire logic [lkf_pkg::FW-1:0] wr_slot,
	input  wire logic [lkf_pkg::FW-1:0] start_slot,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [1:0]              channel_id,
	output logic [7:0]              red_out,
	output logic [7:0]              green_out,
	output logic [7:0]              blue_out,
	output logic                    last_channel
);
	import lkf_pkg::*;
	`include "led_keyframe_fade_engine_top_defines.svh"

	frame_t stage_mem [NUM_FRAMES];
	frame_t act_mem [NUM_FRAMES];
	frame_t stage_rd_q, act_rd_q, cur_q;
	logic [FW-1:0] act_addr;
	logic [NUM_FRAMES-1:0] stage_vld_q, act_vld_q;
	logic          copy_go_s1;
	logic [FW-1:0] copy_idx_s1;
	logic          stage_vld_s1;

	logic [FW-1:0] ch_frame_q [NUM_CHANNELS];
	logic [1:0]    ch_phase_q [NUM_CHANNELS];
	logic [7:0]    ch_step_q  [NUM_CHANNELS];
	logic [23:0]   ch_col_q   [NUM_CHANNELS];

	frame_t cur_f, nxt_f;
	logic [24:0] w_q;
	logic [7:0]  step_inc;
	logic [24:0] recip_tbl [256];

	// reciprocal table 2^24 / d, zero for d = 0
	for (genvar gi = 0; gi < 256; gi++) begin : g_recip
		localparam logic [24:0] RCP = (gi == 0) ? 25'd0 : 25'(32'h1000000 / gi);
		assign recip_tbl[gi] = RCP;
	end

	// staging memory (valid bits give zero reset)
	always_ff @(posedge clk) begin
		if (cmd.stage_wr) stage_mem[wr_slot] <= wr_frame;
		stage_rd_q <= stage_mem[cmd.copy_idx];
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
			act_vld_q <= '0;
			copy_go_s1 <= 1'b0;
			copy_idx_s1 <= '0;
			stage_vld_s1 <= 1'b0;
		end else begin
			if (cmd.stage_wr) stage_vld_q[wr_slot] <= 1'b1;
			copy_go_s1 <= cmd.copy_go;
			copy_idx_s1 <= cmd.copy_idx;
			stage_vld_s1 <= stage_vld_q[cmd.copy_idx];
			if (copy_go_s1) act_vld_q[copy_idx_s1] <= stage_vld_s1;
		end
	end

	// active memory: copy writes in the cycle after the staging read, one read port
	always_comb begin
		if (cmd.rd_start) act_addr = start_slot;
		else if (cmd.rd_nxt) act_addr = cur_f.link;
		else act_addr = ch_frame_q[cmd.ch];
	end
	always_ff @(posedge clk) begin
		if (copy_go_s1)
			act_mem[copy_idx_s1] <= stage_rd_q;
		if (cmd.rd_nxt || cmd.rd_start)
			act_rd_q <= act_vld_q[act_addr] ? act_mem[act_addr] : '0;
		if (cmd.rd_cur) cur_q <= act_vld_q[act_addr] ? act_mem[act_addr] : '0;
	end
	assign cur_f = cur_q;
	assign nxt_f = act_rd_q;

	// weight = step * recip(decay), clamped
	always_ff @(posedge clk) begin
		logic [32:0] prod;
		prod = 33'(ch_step_q[cmd.ch]) * 33'(recip_tbl[cur_f.decay]);
		w_q <= (prod > 33'(ONE_Q24)) ? ONE_Q24 : prod[24:0];
	end

	function automatic logic [7:0] mix(input logic [7:0] a, input logic [7:0] b,
		input logic [24:0] w);
		logic [33:0] m;
		m = 34'(a) * 34'(ONE_Q24 - w) + 34'(b) * 34'(w);
		mix = m[31:24];
	endfunction

	assign step_inc = ch_step_q[cmd.ch] + 8'd1;

	// channel state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				ch_frame_q[i] <= '0;
				ch_phase_q[i] <= PH_STATIC;
				ch_step_q[i]  <= '0;
				ch_col_q[i]   <= '0;
			end
		end else if (cmd.start) begin
			ch_frame_q[cmd.ch] <= start_slot;
			ch_step_q[cmd.ch]  <= '0;
			ch_phase_q[cmd.ch] <= (nxt_f.hold != 0) ? PH_HOLD :
				(nxt_f.decay != 0) ? PH_DECAY : PH_STATIC;
			ch_col_q[cmd.ch]   <= {nxt_f.r, nxt_f.g, nxt_f.b};
		end else if (cmd.adv) begin
			if (ch_phase_q[cmd.ch] == PH_DECAY) begin
				if (cur_f.decay == 0 || step_inc >= cur_f.decay) begin
					ch_frame_q[cmd.ch] <= cur_f.link;
					ch_step_q[cmd.ch]  <= '0;
					ch_phase_q[cmd.ch] <= (nxt_f.hold != 0) ? PH_HOLD :
						(nxt_f.decay != 0) ? PH_DECAY : PH_STATIC;
					ch_col_q[cmd.ch]   <= {nxt_f.r, nxt_f.g, nxt_f.b};
				end else begin
					ch_step_q[cmd.ch] <= step_inc;
					ch_col_q[cmd.ch]  <= {mix(cur_f.r, nxt_f.r, w_q),
						mix(cur_f.g, nxt_f.g, w_q), mix(cur_f.b, nxt_f.b, w_q)};
				end
			end else if (ch_phase_q[cmd.ch] == PH_HOLD) begin
				if (step_inc >= cur_f.hold) begin
					if (cur_f.decay != 0) begin
						ch_phase_q[cmd.ch] <= PH_DECAY;
						ch_step_q[cmd.ch]  <= '0;
					end else begin
						ch_frame_q[cmd.ch] <= cur_f.link;
						ch_step_q[cmd.ch]  <= '0;
						ch_phase_q[cmd.ch] <= (nxt_f.hold != 0) ? PH_HOLD :
							(nxt_f.decay != 0) ? PH_DECAY : PH_STATIC;
						ch_col_q[cmd.ch]   <= {nxt_f.r, nxt_f.g, nxt_f.b};
					end
				end else begin
					ch_step_q[cmd.ch] <= step_inc;
				end
			end
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cmd.emit) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			channel_id   <= 2'(cmd.ch);
			{red_out, green_out, blue_out} <= ch_col_q[cmd.ch];
			last_channel <= cmd.last;
		end
	end
	assign sts.out_busy = out_valid && !out_ready;

	`LKF_ASSERT_IMP(a_emit_free, clk, arst_n, cmd.emit, !sts.out_busy)
	`LKF_ASSERT_IMP(a_one_op, clk, arst_n, cmd.start, !cmd.adv)
	`LKF_ASSERT_NXT(a_emit_vld, clk, arst_n, cmd.emit, out_valid)
endmodule
`default_nettype wire

[design/lkf_ctrl.sv]
// Controller: sequences writes, commits, ticks and channel emission.
`default_nettype none
module lkf_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic [1:0]      mode,
	input  wire logic            cfg_we,
	input  wire logic [7:0]      cfg_data,
	output lkf_pkg::cmd_t        cmd,
	input  wire lkf_pkg::sts_t   sts,
	output logic [lkf_pkg::CW-1:0] start_sel
);
	import lkf_pkg::*;
	`include "led_keyframe_fade_engine_top_defines.svh"

	localparam logic [2:0] S_IDLE = 3'd0, S_COPY = 3'd1, S_START = 3'd2,
		S_RDC = 3'd3, S_RDN = 3'd4, S_WGT = 3'd5, S_ADV = 3'd6, S_EMIT = 3'd7;

	logic [2:0]    state_q;
	logic [7:0]    div_q, pre_q;
	logic [FW:0]   idx_q;
	logic [CW-1:0] ch_q;
	logic          stepping_q, commit_q;
	logic [8:0]    cnt;

	assign cnt = {1'b0, pre_q} + 9'd1;
	assign in_ready = (state_q == S_IDLE);
	assign start_sel = ch_q;

	always_comb begin
		cmd = '0;
		cmd.ch = ch_q;
		cmd.copy_idx = idx_q[FW-1:0];
		cmd.last = (32'(ch_q) == LAST_CH);
		cmd.stage_wr = in_valid && in_ready && mode == MODE_WRITE;
		case (state_q)
			// last copy cycle only drains the write stage
			S_COPY:  cmd.copy_go = !idx_q[FW];
			S_START: cmd.start = 1'b1;
			S_RDC:   cmd.rd_cur = 1'b1;
			S_RDN: begin
				cmd.rd_start = commit_q;
				cmd.rd_nxt = !commit_q;
			end
			S_ADV:   cmd.adv = 1'b1;
			S_EMIT:  cmd.emit = !sts.out_busy;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; div_q <= 8'd6; pre_q <= '0; idx_q <= '0;
			ch_q <= '0; stepping_q <= 1'b0; commit_q <= 1'b0;
		end else begin
			if (cfg_we) div_q <= cfg_data;
			case (state_q)
				S_IDLE: if (in_valid) begin
					ch_q <= '0;
					if (mode == MODE_TICK) begin
						if (cnt < {1'b0, div_q}) begin
							pre_q <= cnt[7:0]; stepping_q <= 1'b0; state_q <= S_EMIT;
						end else begin
							pre_q <= '0; stepping_q <= 1'b1; state_q <= S_RDC;
						end
					end else if (mode == MODE_COMMIT) begin
						idx_q <= '0; commit_q <= 1'b1; state_q <= S_COPY;
					end
				end
				S_COPY: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q[FW]) state_q <= S_RDN;
				end
				S_RDN: state_q <= commit_q ? S_START : S_WGT;
				S_START: state_q <= S_EMIT;
				S_RDC: state_q <= S_RDN;
				S_WGT: state_q <= S_ADV;
				S_ADV: state_q <= S_EMIT;
				S_EMIT: if (!sts.out_busy) begin
					if (32'(ch_q) == LAST_CH) begin
						state_q <= S_IDLE; commit_q <= 1'b0;
					end else begin
						ch_q <= ch_q + 1'b1;
						state_q <= commit_q ? S_RDN : (stepping_q ? S_RDC : S_EMIT);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`LKF_ASSERT_IMP(a_rdy_idle, clk, arst_n, in_ready, state_q == S_IDLE)
	`LKF_ASSERT_NXT(a_copy_go, clk, arst_n, state_q == S_COPY && !idx_q[FW], state_q == S_COPY)
	`LKF_ASSERT_IMP(a_wr_idle, clk, arst_n, cmd.stage_wr, state_q == S_IDLE)
endmodule
`default_nettype wire

[design/led_keyframe_fade_engine_top.sv]
// Top level of the LED keyframe fade engine.
//  channel | signals                               | accepted when
//  in      | in_valid/in_ready, mode..start_ch3    | in_valid && in_ready
//  out     | out_valid/out_ready, channel_id..last | out_valid && out_ready
//  cfg     | cfg_we, cfg_data (tick_divider)       | cfg_we
// Write: a single staging write. Tick without step: one word per channel.
// Animation step: per channel read frame, read link, weight, update, then emit.
// Commit: copy every staging entry (read then write, one active-memory port), then per channel read start, start, emit.
// Reset clears control state; tables read as zero through valid bits.
// A stalled output holds the sequencer in its emit state.
`default_nettype none
module led_keyframe_fade_engine_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] mode,
	input  wire logic [5:0] frame_slot,
	input  wire logic [7:0] red_in,
	input  wire logic [7:0] green_in,
	input  wire logic [7:0] blue_in,
	input  wire logic [7:0] decay_steps,
	input  wire logic [7:0] hold_steps,
	input  wire logic [5:0] next_slot,
	input  wire logic [5:0] start_ch0,
	input  wire logic [5:0] start_ch1,
	input  wire logic [5:0] start_ch2,
	input  wire logic [5:0] start_ch3,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_data,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [1:0]      channel_id,
	output logic [7:0]      red_out,
	output logic [7:0]      green_out,
	output logic [7:0]      blue_out,
	output logic            last_channel
);
	import lkf_pkg::*;

	cmd_t cmd;
	sts_t sts;
	frame_t wr_frame;
	logic [CW-1:0] start_sel;
	logic [5:0] starts [4];
	logic [FW-1:0] start_slot_q;
	logic [5:0] start_hold_q [4];

	assign wr_frame = '{r: red_in, g: green_in, b: blue_in, decay: decay_steps,
		hold: hold_steps, link: next_slot[FW-1:0]};
	assign starts[0] = start_ch0;
	assign starts[1] = start_ch1;
	assign starts[2] = start_ch2;
	assign starts[3] = start_ch3;

	// capture start frames at every accepted input; commit uses them
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			for (int i = 0; i < 4; i++) start_hold_q[i] <= starts[i];
		end
	end
	assign start_slot_q = start_hold_q[2'(start_sel)][FW-1:0];

	lkf_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .mode, .cfg_we, .cfg_data,
		.cmd, .sts, .start_sel
	);

	lkf_datapath u_dp (
		.clk, .arst_n, .cmd, .sts, .wr_frame,
		.wr_slot(frame_slot[FW-1:0]), .start_slot(start_slot_q),
		.out_valid, .out_ready, .channel_id, .red_out, .green_out, .blue_out,
		.last_channel
	);
endmodule
`default_nettype wire
